/* hdl/vrmv_pkg.sv */
package vrmv_pkg;

  // Field widths.
  localparam int CAL_W  = 12;
  localparam int CODE_W = 16;
  localparam int UV_W   = 32;

  // Conversion constants.
  localparam longint unsigned SUPPLY_REF_UV    = 64'd3000000;
  localparam longint unsigned OVERSAMPLE_SCALE = 64'd16;
  localparam int unsigned     CODE_FULL_SCALE  = 32'd65535;
  localparam int unsigned     CALIBRATION_MAX  = 32'd4095;
  localparam logic [CAL_W-1:0] CAL_RESET       = 12'd1671;

  // Dividend of the supply division is the calibration word times NUM_SCALE.
  localparam longint unsigned NUM_SCALE = SUPPLY_REF_UV * OVERSAMPLE_SCALE;
  localparam longint unsigned NUM_MAX   = NUM_SCALE * CALIBRATION_MAX;
  localparam int NUM_W = $clog2(NUM_MAX + 64'd1);

  // Channel product and the full-scale divisor, which is 2**FS_W - 1.
  localparam int PROD_W = CODE_W + UV_W;
  localparam int FS_W   = 16;
  localparam int Y_W    = PROD_W + 2 * FS_W + 1;

  // Operand stage, one stage per quotient bit, three channel stages.
  localparam int PIPE_LAT = 1 + NUM_W + 3;

  typedef logic [CAL_W-1:0] cal_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [CODE_W-1:0] reference_code;
    logic [CODE_W-1:0] channel_code;
  } in_item_t;

  typedef struct packed {
    logic [UV_W-1:0] supply_microvolts;
    logic [UV_W-1:0] channel_microvolts;
    status_t         result_status;
  } out_item_t;

  // Sideband that rides along the divider.
  typedef struct packed {
    logic              arg_invalid;
    logic [CODE_W-1:0] channel_code;
  } div_tag_t;

  typedef struct packed {
    logic [NUM_W-1:0]  numerator;
    logic [CODE_W-1:0] divisor;
    div_tag_t          tag;
  } div_op_t;

endpackage

/* hdl/vrmv_num.sv */
module vrmv_num (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  vrmv_pkg::in_item_t in_item,
  input  vrmv_pkg::cal_t    cal,
  output logic              op_valid,
  output vrmv_pkg::div_op_t op
);
  import vrmv_pkg::*;

  logic    op_valid_r;
  logic    op_valid_nxt;
  div_op_t op_r;
  div_op_t op_nxt;
  logic    cal_bad;
  logic    ref_bad;

  always_comb begin
    cal_bad = (cal == '0) || (32'(cal) > CALIBRATION_MAX);
    ref_bad = (in_item.reference_code == '0) ||
              (32'(in_item.reference_code) > CODE_FULL_SCALE);
    op_valid_nxt          = in_valid;
    op_nxt.numerator      = NUM_W'(cal) * NUM_W'(NUM_SCALE);
    op_nxt.divisor        = in_item.reference_code;
    op_nxt.tag.arg_invalid  = cal_bad || ref_bad;
    op_nxt.tag.channel_code = in_item.channel_code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r <= 1'b0;
    end else begin
      op_valid_r <= op_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
  end

  assign op_valid = op_valid_r;
  assign op       = op_r;

endmodule

/* hdl/vrmv_div.sv */
module vrmv_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      op_valid,
  input  vrmv_pkg::div_op_t         op,
  output logic                      quot_valid,
  output logic [vrmv_pkg::NUM_W-1:0] quot,
  output vrmv_pkg::div_tag_t        quot_tag
);
  import vrmv_pkg::*;

  // Restoring division, one quotient bit per stage. The dividend shifts out
  // of the top of the work word while quotient bits shift in at the bottom.
  logic              vld_r  [NUM_W];
  logic [NUM_W-1:0]  work_r [NUM_W];
  logic [CODE_W-1:0] rem_r  [NUM_W];
  logic [CODE_W-1:0] dvs_r  [NUM_W];
  div_tag_t          tag_r  [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              vld_in;
    logic [NUM_W-1:0]  work_in;
    logic [CODE_W-1:0] rem_in;
    logic [CODE_W-1:0] dvs_in;
    div_tag_t          tag_in;
    logic [CODE_W:0]   rem_sh;
    logic [CODE_W+1:0] diff;
    logic              qbit;
    logic              vld_nxt;
    logic [NUM_W-1:0]  work_nxt;
    logic [CODE_W-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = op_valid;
      assign work_in = op.numerator;
      assign rem_in  = '0;
      assign dvs_in  = op.divisor;
      assign tag_in  = op.tag;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign work_in = work_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign dvs_in  = dvs_r[k-1];
      assign tag_in  = tag_r[k-1];
    end

    always_comb begin
      rem_sh   = {rem_in, work_in[NUM_W-1]};
      diff     = {1'b0, rem_sh} - {2'b00, dvs_in};
      qbit     = ~diff[CODE_W+1];
      rem_nxt  = qbit ? diff[CODE_W-1:0] : rem_sh[CODE_W-1:0];
      work_nxt = {work_in[NUM_W-2:0], qbit};
      vld_nxt  = vld_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_nxt;
      end
    end

    always_ff @(posedge clk) begin
      work_r[k] <= work_nxt;
      rem_r[k]  <= rem_nxt;
      dvs_r[k]  <= dvs_in;
      tag_r[k]  <= tag_in;
    end
  end

  assign quot_valid = vld_r[NUM_W-1];
  assign quot       = work_r[NUM_W-1];
  assign quot_tag   = tag_r[NUM_W-1];

endmodule

/* hdl/vrmv_chan.sv */
module vrmv_chan (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       quot_valid,
  input  logic [vrmv_pkg::NUM_W-1:0] quot,
  input  vrmv_pkg::div_tag_t         quot_tag,
  output logic                       res_strobe,
  output vrmv_pkg::out_item_t        res_item
);
  import vrmv_pkg::*;

  // Stage 1: status and channel product.
  logic              vld1_r, vld1_nxt;
  logic [PROD_W-1:0] prod1_r, prod1_nxt;
  logic [UV_W-1:0]   sup1_r, sup1_nxt;
  status_t           stat1_r, stat1_nxt;
  logic              sup_ovf;
  logic              code_bad;

  always_comb begin
    sup_ovf   = (quot[NUM_W-1:UV_W] != '0);
    code_bad  = (32'(quot_tag.channel_code) > CODE_FULL_SCALE) ||
                (quot[UV_W-1:0] == '0);
    vld1_nxt  = quot_valid;
    sup1_nxt  = quot[UV_W-1:0];
    prod1_nxt = PROD_W'(quot_tag.channel_code) * PROD_W'(quot[UV_W-1:0]);
    if (quot_tag.arg_invalid) begin
      stat1_nxt = STATUS_INVALID;
    end else if (sup_ovf) begin
      stat1_nxt = STATUS_OVERFLOW;
    end else if (code_bad) begin
      stat1_nxt = STATUS_INVALID;
    end else begin
      stat1_nxt = STATUS_OK;
    end
  end

  // Stage 2: quotient estimate for the product over 2**FS_W - 1, taken as
  // x * (2**2W + 2**W + 1) / 2**3W. It is exact or one short.
  logic              vld2_r, vld2_nxt;
  logic [PROD_W-1:0] prod2_r;
  logic [UV_W-1:0]   sup2_r;
  status_t           stat2_r;
  logic [UV_W-1:0]   qest2_r, qest2_nxt;
  logic [Y_W-1:0]    yprod;

  always_comb begin
    yprod = (Y_W'(prod1_r) << (2 * FS_W)) + (Y_W'(prod1_r) << FS_W) + Y_W'(prod1_r);
    qest2_nxt = yprod[3 * FS_W +: UV_W];
    vld2_nxt  = vld1_r;
  end

  // Stage 3: remainder check corrects the estimate; errors zero the values.
  logic        vld3_r, vld3_nxt;
  out_item_t   item3_r, item3_nxt;
  logic [PROD_W-1:0] rem;
  logic [UV_W-1:0]   chan_q;

  always_comb begin
    rem = prod2_r - (PROD_W'(qest2_r) << FS_W) + PROD_W'(qest2_r);
    chan_q = (rem >= PROD_W'(CODE_FULL_SCALE)) ? qest2_r + 1'b1 : qest2_r;
    vld3_nxt = vld2_r;
    item3_nxt.result_status = stat2_r;
    if (stat2_r == STATUS_OK) begin
      item3_nxt.supply_microvolts  = sup2_r;
      item3_nxt.channel_microvolts = chan_q;
    end else begin
      item3_nxt.supply_microvolts  = '0;
      item3_nxt.channel_microvolts = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= vld1_nxt;
      vld2_r <= vld2_nxt;
      vld3_r <= vld3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod1_r <= prod1_nxt;
    sup1_r  <= sup1_nxt;
    stat1_r <= stat1_nxt;
    prod2_r <= prod1_r;
    sup2_r  <= sup1_r;
    stat2_r <= stat1_r;
    qest2_r <= qest2_nxt;
    item3_r <= item3_nxt;
  end

  assign res_strobe = vld3_r;
  assign res_item   = item3_r;

endmodule

/* hdl/vrefint_ratiometric_microvolts_unit.sv */
// Channel   Ports                          Transfer
// input     start, busy, in_data           start high and busy low at a clock edge
// result    out_strobe, out_data           one cycle per result, no back-pressure
// config    cfg_we, cfg_wdata              written at an edge with cfg_we high
//
// One transaction enters every cycle; busy is never raised.
// There are 1 + NUM_W + 3 (42) register stages, set by the bit-per-stage supply
// divider of NUM_W (38) stages; out_strobe and out_data leave the last of them.
// Synchronous reset clears the valid bits and loads the calibration word.
// The receiver cannot stall, so the pipeline never holds.
module vrefint_ratiometric_microvolts_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  vrmv_pkg::in_item_t  in_data,
  output logic                out_strobe,
  output vrmv_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  vrmv_pkg::cal_t      cfg_wdata
);
  import vrmv_pkg::*;

  cal_t cal_r;
  cal_t cal_nxt;
  logic in_accept;

  logic                op_valid;
  div_op_t             op;
  logic                quot_valid;
  logic [NUM_W-1:0]    quot;
  div_tag_t            quot_tag;

  assign busy      = 1'b0;
  assign in_accept = start && !busy;
  assign cal_nxt   = cfg_we ? cfg_wdata : cal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= CAL_RESET;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  vrmv_num u_num (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_accept),
    .in_item  (in_data),
    .cal      (cal_r),
    .op_valid (op_valid),
    .op       (op)
  );

  vrmv_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_valid   (op_valid),
    .op         (op),
    .quot_valid (quot_valid),
    .quot       (quot),
    .quot_tag   (quot_tag)
  );

  vrmv_chan u_chan (
    .clk        (clk),
    .rst_n      (rst_n),
    .quot_valid (quot_valid),
    .quot       (quot),
    .quot_tag   (quot_tag),
    .res_strobe (out_strobe),
    .res_item   (out_data)
  );

  // Every result traces back to a transaction accepted a fixed time earlier.
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, PIPE_LAT))
    else $error("result without an accepted transaction");

  // Any error status clears both values.
  a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.result_status != STATUS_OK) |->
      (out_data.supply_microvolts == '0 && out_data.channel_microvolts == '0))
    else $error("error result carries nonzero values");

  // A channel code within full scale never yields more than the supply.
  a_chan_le_supply: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.result_status == STATUS_OK) |->
      (out_data.channel_microvolts <= out_data.supply_microvolts))
    else $error("channel value exceeds supply");

  // A good result has a nonzero supply.
  a_ok_supply_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.result_status == STATUS_OK) |->
      (out_data.supply_microvolts != '0))
    else $error("good result with zero supply");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import vrmv_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_data = '0;
  logic      out_strobe;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  cal_t      cfg_wdata = '0;

  out_item_t expected_readings[$];
  out_item_t want;
  cal_t      calibration_shadow = CAL_RESET;
  int        error_count = 0;
  int        stall_cycles = 0;
  bit        sender_idles = 1'b1;

  vrefint_ratiometric_microvolts_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Supply from the calibration ratio, then the channel as a fraction of it.
  function automatic out_item_t predict_microvolts(cal_t cal, in_item_t item);
    out_item_t       r;
    longint unsigned supply;
    longint unsigned chan;
    r = '0;
    r.result_status = STATUS_OK;
    if (cal == 0 || cal > CALIBRATION_MAX) begin
      r.result_status = STATUS_INVALID;
    end else if (item.reference_code == 0 || item.reference_code > CODE_FULL_SCALE) begin
      r.result_status = STATUS_INVALID;
    end else begin
      supply = (SUPPLY_REF_UV * longint'(cal) * OVERSAMPLE_SCALE)
               / longint'(item.reference_code);
      if (supply > 64'hFFFF_FFFF) begin
        r.result_status = STATUS_OVERFLOW;
      end else if (supply == 0 || item.channel_code > CODE_FULL_SCALE) begin
        r.result_status = STATUS_INVALID;
      end else begin
        chan = (longint'(item.channel_code) * supply) / longint'(CODE_FULL_SCALE);
        if (chan > 64'hFFFF_FFFF) begin
          r.result_status = STATUS_OVERFLOW;
        end else begin
          r.supply_microvolts  = supply[UV_W-1:0];
          r.channel_microvolts = chan[UV_W-1:0];
        end
      end
    end
    return r;
  endfunction

  // Results are checked before new transactions are queued, so a stray strobe
  // can never match an item accepted at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: result with none expected, got %p", $time, out_data);
          error_count++;
        end else begin
          want = expected_readings.pop_front();
          if (out_data.supply_microvolts !== want.supply_microvolts) begin
            $display("%0t: supply_microvolts expected %0d got %0d", $time,
                     want.supply_microvolts, out_data.supply_microvolts);
            error_count++;
          end
          if (out_data.channel_microvolts !== want.channel_microvolts) begin
            $display("%0t: channel_microvolts expected %0d got %0d", $time,
                     want.channel_microvolts, out_data.channel_microvolts);
            error_count++;
          end
          if (out_data.result_status !== want.result_status) begin
            $display("%0t: result_status expected %0d got %0d", $time,
                     want.result_status, out_data.result_status);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        expected_readings.push_back(predict_microvolts(calibration_shadow, in_data));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Start is left high after a transaction so back-to-back items keep it up.
  task automatic send_reading(logic [CODE_W-1:0] ref_code, logic [CODE_W-1:0] chan_code);
    in_item_t item;
    item.reference_code = ref_code;
    item.channel_code   = chan_code;
    while (sender_idles && $urandom_range(99) < 24) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_readings();
    start <= 1'b0;
    do @(posedge clk); while (expected_readings.size() != 0);
  endtask

  task automatic write_calibration(cal_t value);
    drain_readings();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    calibration_shadow = value;
  endtask

  task automatic test_reset_calibration();
    send_reading(16'd0, 16'd1234);
    send_reading(16'd1, 16'hFFFF);
    send_reading(16'd18, 16'd100);
    send_reading(16'd19, 16'd100);
    send_reading(16'hFFFF, 16'hFFFF);
    send_reading(16'hFFFF, 16'd0);
    send_reading(16'h5555, 16'hAAAA);
    send_reading(16'hAAAA, 16'h5555);
    send_reading(16'd26720, 16'd32768);
  endtask

  task automatic test_calibration_extremes();
    write_calibration(cal_t'(0));
    send_reading(16'd26720, 16'd1000);
    send_reading(16'hFFFF, 16'hFFFF);
    write_calibration(cal_t'(CALIBRATION_MAX));
    send_reading(16'd1, 16'd5);
    send_reading(16'd45, 16'hFFFF);
    send_reading(16'd46, 16'hFFFF);
    send_reading(16'hFFFF, 16'hFFFF);
    write_calibration(cal_t'(1));
    send_reading(16'hFFFF, 16'hFFFF);
    send_reading(16'hFFFF, 16'd1);
    send_reading(16'd1, 16'hFFFF);
    send_reading(16'd0, 16'd0);
  endtask

  // Mostly valid reference codes, with zero and the overflow region hit often.
  task automatic test_random_readings(int count);
    logic [CODE_W-1:0] ref_code;
    logic [CODE_W-1:0] chan_code;
    int                pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 5) ref_code = '0;
      else if (pick < 20) ref_code = CODE_W'($urandom_range(1, 64));
      else if (pick < 25) ref_code = '1;
      else ref_code = CODE_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 5) chan_code = '0;
      else if (pick < 10) chan_code = '1;
      else chan_code = CODE_W'($urandom);
      send_reading(ref_code, chan_code);
    end
  endtask

  task automatic test_drained_restart();
    test_random_readings(30);
    drain_readings();
    test_random_readings(30);
  endtask

  task automatic test_calibration_sweep();
    write_calibration(CAL_RESET);
    test_random_readings(400);
    write_calibration(cal_t'(CALIBRATION_MAX));
    sender_idles = 1'b0;
    test_random_readings(300);
    sender_idles = 1'b1;
    write_calibration(cal_t'($urandom_range(1, CALIBRATION_MAX)));
    test_random_readings(300);
    write_calibration(cal_t'(1));
    test_random_readings(250);
    write_calibration(cal_t'(0));
    test_random_readings(20);
    write_calibration(cal_t'($urandom_range(1, CALIBRATION_MAX)));
    test_random_readings(380);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_calibration();
    test_calibration_extremes();
    test_drained_restart();
    test_calibration_sweep();
    drain_readings();
    repeat (PIPE_LAT + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/vrmv_pkg.sv
hdl/vrmv_num.sv
hdl/vrmv_div.sv
hdl/vrmv_chan.sv
hdl/vrefint_ratiometric_microvolts_unit.sv
dv/tb_top.sv
